// ===== sv/usbsw_pkg.sv =====
// Shared types, register indexes and command codes for the USB host share switch policy.
package usbsw_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE_FLAGS  = 3'd0;
  localparam logic [2:0] REG_ON_THRESH   = 3'd1;
  localparam logic [2:0] REG_OFF_THRESH  = 3'd2;
  localparam logic [2:0] REG_ON_DWELL    = 3'd3;
  localparam logic [2:0] REG_OFF_DWELL   = 3'd4;
  localparam logic [2:0] REG_SHORT_MIN   = 3'd5;
  localparam logic [2:0] REG_LONG_MIN    = 3'd6;

  // Mode flag bit positions
  localparam int MF_STARTUP_FIRST     = 0;
  localparam int MF_FIRST_AVAILABLE   = 1;
  localparam int MF_CHANGE_CONNECT    = 2;
  localparam int MF_CHANGE_DISCONNECT = 3;
  localparam int MF_SELECT_UNPOWERED  = 4;
  localparam int MF_DISCONNECT_ALL    = 5;

  // Switch command codes
  localparam logic [1:0] TGT_DISCONNECT = 2'd0;
  localparam logic [1:0] TGT_CH1        = 2'd1;
  localparam logic [1:0] TGT_CH2        = 2'd2;

  localparam int NUM_CH    = 2;
  localparam int NUM_SLOTS = 4;

  typedef struct packed {
    logic [5:0]  mode_flags;
    logic [12:0] on_threshold_mv;
    logic [12:0] off_threshold_mv;
    logic [7:0]  on_dwell_ticks;
    logic [7:0]  off_dwell_ticks;
    logic [11:0] short_press_min;
    logic [11:0] long_press_min;
  } cfg_t;

  // Command bundle of one tick: slots in issue order, a mask of slots in use
  typedef struct packed {
    logic [NUM_SLOTS-1:0]      mask;
    logic [NUM_SLOTS-1:0][1:0] port;
  } bundle_t;

  function automatic logic [1:0] chan_code(input logic ch);
    return ch ? TGT_CH2 : TGT_CH1;
  endfunction

endpackage

// ===== sv/usbsw_front.sv =====
// Front end: takes ticks, runs the power qualifiers and button logic, builds a command bundle.
module usbsw_front
  import usbsw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          tick_fire,
  input  logic [12:0]   vbus_mv_a,
  input  logic [12:0]   vbus_mv_b,
  input  logic          key_a_released,
  input  logic          key_a_held,
  input  logic [11:0]   key_a_duration,
  input  logic          key_b_released,
  input  logic          key_b_held,
  input  logic [11:0]   key_b_duration,
  output bundle_t       bundle,
  output logic          bundle_push
);

  logic [NUM_CH-1:0]      powered_r, powered_nxt;
  logic [NUM_CH-1:0][8:0] dwell_r, dwell_nxt;
  logic                   startup_r, startup_nxt;
  logic [NUM_CH-1:0]      latch_r, latch_nxt;

  logic [NUM_CH-1:0][12:0] volt;
  logic [NUM_CH-1:0]       rel, held;
  logic [NUM_CH-1:0][11:0] dur;
  logic [NUM_CH-1:0]       changed;

  assign volt = {vbus_mv_b, vbus_mv_a};
  assign rel  = {key_b_released, key_a_released};
  assign held = {key_b_held, key_a_held};
  assign dur  = {key_b_duration, key_a_duration};

  // Qualify power, handle buttons, apply channel policy
  always_comb begin
    logic       cond;
    logic [7:0] dwell_lim;
    logic [8:0] cnt_inc;
    powered_nxt = powered_r;
    dwell_nxt   = dwell_r;
    startup_nxt = startup_r;
    latch_nxt   = latch_r;
    changed     = '0;
    bundle.mask = '0;
    bundle.port = '0;

    for (int i = 0; i < NUM_CH; i++) begin
      cond      = powered_r[i] ? (volt[i] <= cfg.off_threshold_mv)
                               : (volt[i] >= cfg.on_threshold_mv);
      dwell_lim = powered_r[i] ? cfg.off_dwell_ticks : cfg.on_dwell_ticks;
      cnt_inc   = dwell_r[i] + 9'd1;
      if (cond) begin
        if (cnt_inc > {1'b0, dwell_lim}) begin
          powered_nxt[i] = ~powered_r[i];
          changed[i]     = 1'b1;
          dwell_nxt[i]   = '0;
        end else begin
          dwell_nxt[i]   = cnt_inc;
        end
      end else begin
        dwell_nxt[i] = '0;
      end
    end

    // Buttons: slot 0 for button 1, slot 1 for button 2
    for (int i = 0; i < NUM_CH; i++) begin
      if (!held[i]) latch_nxt[i] = 1'b0;
      if (rel[i]) begin
        if (dur[i] >= cfg.short_press_min && dur[i] < cfg.long_press_min &&
            (cfg.mode_flags[MF_SELECT_UNPOWERED] || powered_nxt[i])) begin
          bundle.mask[i] = 1'b1;
          bundle.port[i] = chan_code(i[0]);
        end
      end else if (held[i] && !latch_nxt[i] && dur[i] > cfg.long_press_min) begin
        latch_nxt[i] = 1'b1;
        if (i == 0 && cfg.mode_flags[MF_DISCONNECT_ALL]) begin
          bundle.mask[i] = 1'b1;
          bundle.port[i] = TGT_DISCONNECT;
        end
      end
    end

    // Channel policy: slots 2 and 3
    for (int i = 0; i < NUM_CH; i++) begin
      if (changed[i]) begin
        if (powered_nxt[i] && cfg.mode_flags[MF_CHANGE_CONNECT]) begin
          bundle.mask[2+i] = 1'b1;
          bundle.port[2+i] = chan_code(i[0]);
        end else if (!powered_nxt[i] && cfg.mode_flags[MF_CHANGE_DISCONNECT]) begin
          if (powered_nxt != '0) begin
            bundle.mask[2+i] = 1'b1;
            bundle.port[2+i] = powered_nxt[0] ? TGT_CH1 : TGT_CH2;
          end
        end else if (powered_nxt[i] && cfg.mode_flags[MF_FIRST_AVAILABLE]) begin
          if (powered_nxt[0] ^ powered_nxt[1]) begin
            bundle.mask[2+i] = 1'b1;
            bundle.port[2+i] = chan_code(i[0]);
          end
        end
      end else if (cfg.mode_flags[MF_STARTUP_FIRST] && startup_nxt && powered_nxt[i]) begin
        startup_nxt      = 1'b0;
        bundle.mask[2+i] = 1'b1;
        bundle.port[2+i] = chan_code(i[0]);
      end
    end
  end

  assign bundle_push = tick_fire && (bundle.mask != '0);

  // Commit state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r <= '0;
      dwell_r   <= '0;
      startup_r <= 1'b1;
      latch_r   <= '0;
    end else if (tick_fire) begin
      powered_r <= powered_nxt;
      dwell_r   <= dwell_nxt;
      startup_r <= startup_nxt;
      latch_r   <= latch_nxt;
    end
  end

endmodule

// ===== sv/usbsw_cmdq.sv =====
// Two-entry queue of command bundles between the front end and the issue stage.
module usbsw_cmdq
  import usbsw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    not_empty,
  output logic    full
);

  bundle_t    ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head      = ent_r[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== sv/usbsw_issue.sv =====
// Issue stage: drains one bundle at a time and sends its commands one per cycle while out_tready is high.
module usbsw_issue
  import usbsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    q_head,
  input  logic       q_not_empty,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_port,
  output logic       out_last
);

  logic [NUM_SLOTS-1:0]      mask_r, mask_nxt;
  logic [NUM_SLOTS-1:0][1:0] port_r;
  logic                      ovalid_r, ovalid_nxt;
  logic [1:0]                oport_r;
  logic                      olast_r;

  logic                      out_load;
  logic [NUM_SLOTS-1:0]      rem_mask;
  logic [1:0]                sel_port;

  assign out_load = (mask_r != '0) && (!ovalid_r || out_tready);

  // Pick the first slot in use and clear it
  always_comb begin
    logic found;
    found    = 1'b0;
    rem_mask = mask_r;
    sel_port = TGT_DISCONNECT;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (!found && mask_r[k]) begin
        found       = 1'b1;
        rem_mask[k] = 1'b0;
        sel_port    = port_r[k];
      end
    end
  end

  assign q_pop = q_not_empty && ((mask_r == '0) || (out_load && rem_mask == '0));

  always_comb begin
    mask_nxt = out_load ? rem_mask : mask_r;
    if (q_pop) mask_nxt = q_head.mask;
    ovalid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : ovalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Hold payload of bundle and output register
  always_ff @(posedge clk) begin
    if (q_pop) port_r <= q_head.port;
    if (out_load) begin
      oport_r <= sel_port;
      olast_r <= (rem_mask == '0);
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_port   = oport_r;
  assign out_last   = olast_r;

endmodule

// ===== sv/usb_host_share_switch_policy_top.sv =====
// Top level of the USB host share switch policy: configuration registers and the front/queue/issue chain.
// One tick is accepted per cycle while the two-entry bundle queue has room; the front end qualifies
// power and buttons for a tick in that cycle. A tick produces zero to four switch commands, which
// the issue stage sends one per cycle through its output register while out_tready is high; a tick
// without commands is accepted but puts nothing into the queue.
// target_port 0 disconnects all, 1 or 2 selects that channel; tlast marks the tick's final command.
module usb_host_share_switch_policy_top
  import usbsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Tick input; tdata from bit 0: vbus_mv_a[12:0], vbus_mv_b[12:0], key_a_released,
  // key_a_held, key_a_duration[11:0], key_b_released, key_b_held, key_b_duration[11:0], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // Command output; tdata from bit 0: target_port[1:0], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);

  cfg_t       cfg_r;
  bundle_t    fe_bundle, q_head;
  logic       fe_push, q_pop, q_not_empty, q_full, tick_fire;
  logic [1:0] out_port;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_flags       <= 6'd63;
      cfg_r.on_threshold_mv  <= 13'd4500;
      cfg_r.off_threshold_mv <= 13'd3000;
      cfg_r.on_dwell_ticks   <= 8'd10;
      cfg_r.off_dwell_ticks  <= 8'd5;
      cfg_r.short_press_min  <= 12'd20;
      cfg_r.long_press_min   <= 12'd500;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE_FLAGS: cfg_r.mode_flags       <= cfg_wdata[5:0];
        REG_ON_THRESH:  cfg_r.on_threshold_mv  <= cfg_wdata;
        REG_OFF_THRESH: cfg_r.off_threshold_mv <= cfg_wdata;
        REG_ON_DWELL:   cfg_r.on_dwell_ticks   <= cfg_wdata[7:0];
        REG_OFF_DWELL:  cfg_r.off_dwell_ticks  <= cfg_wdata[7:0];
        REG_SHORT_MIN:  cfg_r.short_press_min  <= cfg_wdata[11:0];
        REG_LONG_MIN:   cfg_r.long_press_min   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  assign in_tready = ~q_full;
  assign tick_fire = in_tvalid & in_tready;

  usbsw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .tick_fire      (tick_fire),
    .vbus_mv_a      (in_tdata[12:0]),
    .vbus_mv_b      (in_tdata[25:13]),
    .key_a_released (in_tdata[26]),
    .key_a_held     (in_tdata[27]),
    .key_a_duration (in_tdata[39:28]),
    .key_b_released (in_tdata[40]),
    .key_b_held     (in_tdata[41]),
    .key_b_duration (in_tdata[53:42]),
    .bundle         (fe_bundle),
    .bundle_push    (fe_push)
  );

  usbsw_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_push),
    .push_data (fe_bundle),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  usbsw_issue u_issue (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_head      (q_head),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_port    (out_port),
    .out_last    (out_tlast)
  );

  assign out_tdata = {6'd0, out_port};

endmodule

// ===== verif/tb_usb_host_share_switch_policy_top.sv =====
// Self-checking testbench for the USB host share switch policy: directed and random ticks.
module tb_usb_host_share_switch_policy_top;
  timeunit 1ns;
  timeprecision 1ps;
  import usbsw_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 16;

  // One tick as packed on in_tdata, last member in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic [11:0] key_b_duration;
    logic        key_b_held;
    logic        key_b_released;
    logic [11:0] key_a_duration;
    logic        key_a_held;
    logic        key_a_released;
    logic [12:0] vbus_mv_b;
    logic [12:0] vbus_mv_a;
  } host_tick_t;

  typedef struct packed {
    logic [1:0] port;
    logic       last;
  } switch_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [12:0] cfg_wdata;

  // Shadow of the policy: registers and per-channel state
  cfg_t        policy_cfg;
  logic        ch_powered [2];
  logic [8:0]  dwell_cnt [2];
  logic        long_latch [2];
  logic        startup_pend;

  switch_cmd_t pending_cmds [$];
  int          rail_level [2];
  int          fail_count;
  int          ticks_sent;
  int          cmds_checked;
  int          cfg_writes;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycle_count;

  usb_host_share_switch_policy_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[usb_host_share_switch_policy_top] ERROR");
      $finish;
    end
  end

  // Stall the command side at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every command transfer with the oldest expected command
  always @(posedge clk) begin : check_cmds
    switch_cmd_t exp_cmd;
    if (out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected command: target_port %0d, last_command %0b",
               out_tdata[1:0], out_tlast);
        fail_count++;
      end else begin
        exp_cmd = pending_cmds.pop_front();
        cmds_checked++;
        if (out_tdata[1:0] !== exp_cmd.port) begin
          $error("target_port: expected %0d, actual %0d", exp_cmd.port, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tlast !== exp_cmd.last) begin
          $error("last_command: expected %0b, actual %0b", exp_cmd.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Advance the shadow state by one tick and queue the commands it issues
  task automatic apply_policy_tick(input host_tick_t t);
    logic [12:0] volt [2];
    logic        rel [2];
    logic        held [2];
    logic [11:0] dur [2];
    logic        changed [2];
    logic        hit;
    logic [8:0]  limit;
    logic [1:0]  cmds [4];
    int          n;
    switch_cmd_t cmd;
    n = 0;
    volt[0] = t.vbus_mv_a;
    volt[1] = t.vbus_mv_b;
    rel[0]  = t.key_a_released;
    held[0] = t.key_a_held;
    dur[0]  = t.key_a_duration;
    rel[1]  = t.key_b_released;
    held[1] = t.key_b_held;
    dur[1]  = t.key_b_duration;

    // Qualify power with hysteresis and dwell
    for (int i = 0; i < 2; i++) begin
      if (ch_powered[i]) begin
        hit   = (volt[i] <= policy_cfg.off_threshold_mv);
        limit = {1'b0, policy_cfg.off_dwell_ticks};
      end else begin
        hit   = (volt[i] >= policy_cfg.on_threshold_mv);
        limit = {1'b0, policy_cfg.on_dwell_ticks};
      end
      changed[i] = 1'b0;
      if (hit) begin
        dwell_cnt[i] = dwell_cnt[i] + 9'd1;
        if (dwell_cnt[i] > limit) begin
          ch_powered[i] = !ch_powered[i];
          changed[i]    = 1'b1;
          dwell_cnt[i]  = '0;
        end
      end else begin
        dwell_cnt[i] = '0;
      end
    end

    // Buttons: short press selects, long press on button 1 disconnects
    for (int i = 0; i < 2; i++) begin
      if (!held[i])
        long_latch[i] = 1'b0;
      if (rel[i]) begin
        if (dur[i] >= policy_cfg.short_press_min && dur[i] < policy_cfg.long_press_min &&
            (policy_cfg.mode_flags[MF_SELECT_UNPOWERED] || ch_powered[i])) begin
          cmds[n] = (i == 0) ? TGT_CH1 : TGT_CH2;
          n++;
        end
      end else if (held[i] && !long_latch[i] && dur[i] > policy_cfg.long_press_min) begin
        long_latch[i] = 1'b1;
        if (i == 0 && policy_cfg.mode_flags[MF_DISCONNECT_ALL]) begin
          cmds[n] = TGT_DISCONNECT;
          n++;
        end
      end
    end

    // Power change policy, else the one-shot startup pick
    for (int i = 0; i < 2; i++) begin
      if (changed[i]) begin
        if (ch_powered[i] && policy_cfg.mode_flags[MF_CHANGE_CONNECT]) begin
          cmds[n] = (i == 0) ? TGT_CH1 : TGT_CH2;
          n++;
        end else if (!ch_powered[i] && policy_cfg.mode_flags[MF_CHANGE_DISCONNECT]) begin
          if (ch_powered[0] || ch_powered[1]) begin
            cmds[n] = ch_powered[0] ? TGT_CH1 : TGT_CH2;
            n++;
          end
        end else if (ch_powered[i] && policy_cfg.mode_flags[MF_FIRST_AVAILABLE]) begin
          if (ch_powered[0] != ch_powered[1]) begin
            cmds[n] = (i == 0) ? TGT_CH1 : TGT_CH2;
            n++;
          end
        end
      end else if (policy_cfg.mode_flags[MF_STARTUP_FIRST] && startup_pend && ch_powered[i]) begin
        startup_pend = 1'b0;
        cmds[n] = (i == 0) ? TGT_CH1 : TGT_CH2;
        n++;
      end
    end

    for (int k = 0; k < n; k++) begin
      cmd.port = cmds[k];
      cmd.last = (k == n - 1);
      pending_cmds.push_back(cmd);
    end
  endtask

  // Offer one tick after a random gap; predict at the transfer
  task automatic send_tick(input host_tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = t;
    do @(posedge clk); while (in_tready !== 1'b1);
    apply_policy_tick(t);
    ticks_sent++;
  endtask

  // Hold off input until every expected command has arrived
  task automatic wait_for_commands();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_cmds.size() != 0)
      @(posedge clk);
  endtask

  // Drain, then let ticks without commands leave the pipeline
  task automatic quiesce();
    wait_for_commands();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [12:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (addr)
      REG_MODE_FLAGS: policy_cfg.mode_flags       = value[5:0];
      REG_ON_THRESH:  policy_cfg.on_threshold_mv  = value;
      REG_OFF_THRESH: policy_cfg.off_threshold_mv = value;
      REG_ON_DWELL:   policy_cfg.on_dwell_ticks   = value[7:0];
      REG_OFF_DWELL:  policy_cfg.off_dwell_ticks  = value[7:0];
      REG_SHORT_MIN:  policy_cfg.short_press_min  = value[11:0];
      REG_LONG_MIN:   policy_cfg.long_press_min   = value[11:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_policy(input int mode, input int on_mv, input int off_mv, input int on_dw,
                            input int off_dw, input int short_min, input int long_min);
    quiesce();
    write_reg(REG_MODE_FLAGS, 13'(mode));
    write_reg(REG_ON_THRESH, 13'(on_mv));
    write_reg(REG_OFF_THRESH, 13'(off_mv));
    write_reg(REG_ON_DWELL, 13'(on_dw));
    write_reg(REG_OFF_DWELL, 13'(off_dw));
    write_reg(REG_SHORT_MIN, 13'(short_min));
    write_reg(REG_LONG_MIN, 13'(long_min));
  endtask

  function automatic host_tick_t make_tick(input int va, input int vb, input int ra, input int ha,
                                           input int da, input int rb, input int hb, input int db);
    host_tick_t t;
    t = '0;
    t.vbus_mv_a      = 13'(va);
    t.vbus_mv_b      = 13'(vb);
    t.key_a_released = 1'(ra);
    t.key_a_held     = 1'(ha);
    t.key_a_duration = 12'(da);
    t.key_b_released = 1'(rb);
    t.key_b_held     = 1'(hb);
    t.key_b_duration = 12'(db);
    return t;
  endfunction

  // Pick a button state with durations clustered on the press thresholds
  task automatic pick_press(output logic rel, output logic held, output logic [11:0] dur);
    int r;
    r = $urandom_range(99);
    rel  = (r >= 60);
    held = (r >= 35 && r < 60) || (r >= 90);
    case ($urandom_range(7))
      0: dur = policy_cfg.short_press_min - 12'd1;
      1: dur = policy_cfg.short_press_min;
      2: dur = policy_cfg.long_press_min - 12'd1;
      3: dur = policy_cfg.long_press_min;
      4: dur = policy_cfg.long_press_min + 12'd1;
      5: dur = 12'($urandom_range(4095));
      6: dur = 12'($urandom_range(policy_cfg.long_press_min, policy_cfg.short_press_min));
      default: dur = $urandom_range(1) ? 12'd0 : 12'd4095;
    endcase
  endtask

  // Rails hold a level band for a few ticks so the dwell counters can run out
  task automatic random_tick(output host_tick_t t);
    logic [12:0] v [2];
    t = '0;
    for (int i = 0; i < 2; i++) begin
      if ($urandom_range(3) == 0)
        rail_level[i] = $urandom_range(2);
      case (rail_level[i])
        0:       v[i] = 13'($urandom_range(policy_cfg.off_threshold_mv, 0));
        1:       v[i] = 13'($urandom_range(8191, policy_cfg.on_threshold_mv));
        default: v[i] = 13'($urandom_range(8191));
      endcase
    end
    t.vbus_mv_a = v[0];
    t.vbus_mv_b = v[1];
    pick_press(t.key_a_released, t.key_a_held, t.key_a_duration);
    pick_press(t.key_b_released, t.key_b_held, t.key_b_duration);
  endtask

  // Press thresholds, release with held, repeated long press, long press on button 2
  task automatic test_button_edges();
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(8191, 8191, 1, 0, 20, 1, 0, 499));
    send_tick(make_tick(8191, 8191, 0, 1, 501, 0, 1, 4095));
    send_tick(make_tick(8191, 8191, 0, 1, 4095, 0, 1, 4095));
    send_tick(make_tick(0, 0, 1, 1, 100, 0, 0, 0));
    send_tick(make_tick(0, 0, 1, 0, 19, 1, 0, 500));
    send_tick(make_tick(0, 0, 0, 1, 500, 1, 1, 4095));
  endtask

  // Auto-connect, startup pick, fall-back with and without a powered channel
  task automatic test_power_transitions();
    quiesce();
    write_reg(REG_ON_DWELL, 13'd0);
    write_reg(REG_OFF_DWELL, 13'd0);
    send_tick(make_tick(8191, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(8191, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(8191, 8191, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 8191, 0, 0, 0, 1, 0, 30));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // First-available alone, then every mode flag off
  task automatic test_mode_gates();
    quiesce();
    write_reg(REG_MODE_FLAGS, 13'(1 << MF_FIRST_AVAILABLE));
    send_tick(make_tick(8191, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(8191, 8191, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    quiesce();
    write_reg(REG_MODE_FLAGS, 13'd0);
    send_tick(make_tick(0, 0, 0, 1, 4095, 0, 0, 0));
    send_tick(make_tick(0, 0, 1, 0, 100, 1, 0, 100));
    send_tick(make_tick(0, 8191, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 8191, 0, 0, 0, 1, 0, 100));
  endtask

  // Thresholds and press limits at their extremes
  task automatic test_config_extremes();
    quiesce();
    write_reg(REG_MODE_FLAGS, 13'd63);
    write_reg(REG_ON_THRESH, 13'd0);
    write_reg(REG_OFF_THRESH, 13'd8191);
    write_reg(REG_SHORT_MIN, 13'd0);
    write_reg(REG_LONG_MIN, 13'd0);
    send_tick(make_tick(0, 8191, 0, 1, 1, 1, 0, 0));
    send_tick(make_tick(8191, 0, 1, 1, 0, 0, 1, 4095));
    send_tick(make_tick(4095, 4096, 0, 1, 4095, 1, 1, 2048));
    quiesce();
    write_reg(REG_SHORT_MIN, 13'd4095);
    write_reg(REG_LONG_MIN, 13'd4095);
    send_tick(make_tick(0, 0, 1, 0, 4095, 1, 0, 4094));
  endtask

  // Random ticks under the current policy; optionally drain once midway
  task automatic test_random_traffic(input int count, input bit pause_midway);
    host_tick_t t;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2)
        wait_for_commands();
      random_tick(t);
      send_tick(t);
    end
  endtask

  initial begin
    int on_mv;
    int short_min;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_MODE_FLAGS;
    cfg_wdata  = '0;
    fail_count   = 0;
    ticks_sent   = 0;
    cmds_checked = 0;
    cfg_writes   = 0;
    cycle_count  = 0;
    send_idle_pct = 29;
    recv_idle_pct = 74;
    rail_level[0] = 0;
    rail_level[1] = 0;

    // Reset values of the registers and the channel state
    policy_cfg.mode_flags       = 6'd63;
    policy_cfg.on_threshold_mv  = 13'd4500;
    policy_cfg.off_threshold_mv = 13'd3000;
    policy_cfg.on_dwell_ticks   = 8'd10;
    policy_cfg.off_dwell_ticks  = 8'd5;
    policy_cfg.short_press_min  = 12'd20;
    policy_cfg.long_press_min   = 12'd500;
    for (int i = 0; i < 2; i++) begin
      ch_powered[i] = 1'b0;
      dwell_cnt[i]  = '0;
      long_latch[i] = 1'b0;
    end
    startup_pend = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_button_edges();
    test_power_transitions();
    test_mode_gates();
    test_config_extremes();

    set_policy(63, 4500, 3000, 1, 2, 20, 500);
    test_random_traffic(75, 1'b1);

    set_policy($urandom_range(63), $urandom_range(6000, 3000), $urandom_range(2999, 500),
               0, 0, 0, 4095);
    send_idle_pct = 74;
    recv_idle_pct = 29;
    test_random_traffic(75, 1'b0);

    set_policy($urandom_range(63), 8191, 0, 255, 255, 0, 4095);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(30, 1'b0);

    on_mv     = $urandom_range(6000, 3000);
    short_min = $urandom_range(50);
    set_policy($urandom_range(63), on_mv, $urandom_range(on_mv, 1000), $urandom_range(3),
               $urandom_range(3), short_min, $urandom_range(600, short_min));
    test_random_traffic(40, 1'b0);

    quiesce();
    $display("Sent %0d ticks, checked %0d switch commands, %0d register writes",
             ticks_sent, cmds_checked, cfg_writes);
    $display("Covered button edges, power hysteresis, mode gates and three stall patterns");
    if (fail_count == 0) begin
      $display("[usb_host_share_switch_policy_top] OK");
    end else begin
      $display("[usb_host_share_switch_policy_top] ERROR");
    end
    $finish;
  end

endmodule
